// ===== sv/sema_pkg.sv =====
package sema_pkg;

  // Q30 fixed point for the trig polynomials
  localparam logic [31:0] Q30_ONE      = 32'h4000_0000;
  localparam logic [31:0] RAD_PER_UNIT = 32'd102944;
  localparam logic [14:0] TRIG_MAX     = 15'h7FFF;
  localparam logic [63:0] ROUND_HALF   = 64'd8192;
  localparam logic [63:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

  // constant division by reciprocal multiply, exact for numerators below 2^30
  localparam int unsigned SH_42 = 36;
  localparam int unsigned SH_20 = 35;
  localparam int unsigned SH_6  = 33;
  localparam int unsigned SH_56 = 36;
  localparam int unsigned SH_30 = 35;
  localparam int unsigned SH_12 = 34;
  localparam logic [31:0] RCP_42 = 32'((64'd1 << SH_42) / 64'd42 + 64'd1);
  localparam logic [31:0] RCP_20 = 32'((64'd1 << SH_20) / 64'd20 + 64'd1);
  localparam logic [31:0] RCP_6  = 32'((64'd1 << SH_6) / 64'd6 + 64'd1);
  localparam logic [31:0] RCP_56 = 32'((64'd1 << SH_56) / 64'd56 + 64'd1);
  localparam logic [31:0] RCP_30 = 32'((64'd1 << SH_30) / 64'd30 + 64'd1);
  localparam logic [31:0] RCP_12 = 32'((64'd1 << SH_12) / 64'd12 + 64'd1);

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_TX, OP_TX2, OP_SD42, OP_MT2, OP_SD20, OP_SD6, OP_SMX,
    OP_CD56, OP_CD30, OP_CD12, OP_CFIN, OP_ACC_C, OP_ACC_S, OP_DIV_MEAN,
    OP_MEAN_CAP, OP_MAGS, OP_PLL, OP_PLH, OP_PHL, OP_DEV, OP_DIV_DEV,
    OP_RND_CAP, OP_SQA, OP_SQB, OP_SQRT, OP_EMIT
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_TX, ST_TX2, ST_SD42, ST_SM1, ST_SD20, ST_SM2, ST_SD6, ST_SMX,
    ST_CD56, ST_CM1, ST_CD30, ST_CM2, ST_CD12, ST_CM3, ST_CFIN, ST_ACC_C,
    ST_ACC_S, ST_CLOSE, ST_WMEAN,
    ST_MAGS_C, ST_PLL_C, ST_PLH_C, ST_PHL_C, ST_DEV_C, ST_DIV_C, ST_WDIV_C,
    ST_MAGS_S, ST_PLL_S, ST_PLH_S, ST_PHL_S, ST_DEV_S, ST_DIV_S, ST_WDIV_S,
    ST_SQA, ST_SQB, ST_SQRT, ST_WSQRT, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic sine;
  } dp_cmd_t;

  typedef struct packed {
    logic count_full;
    logic count_zero;
    logic div_done;
    logic sqrt_done;
  } dp_stat_t;

  // round Q30 to Q1.15 and clamp
  function automatic logic [14:0] q30_to_q15(input logic [31:0] v);
    logic [31:0] s;
    logic [16:0] r;
    s = v + 32'h0000_4000;
    r = s[31:15];
    return (r > {2'b00, TRIG_MAX}) ? TRIG_MAX : r[14:0];
  endfunction

endpackage

// ===== sv/sema_in_if.sv =====
interface sema_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] gamma;
  logic [15:0] phase;
  logic        last;
  logic        empty_slice;

  modport source (output valid, gamma, phase, last, empty_slice, input ready);
  modport sink (input valid, gamma, phase, last, empty_slice, output ready);
endinterface

// ===== sv/sema_out_if.sv =====
interface sema_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] amplitude;
  logic [16:0] particle_count;
  logic        saturated;

  modport source (output valid, amplitude, particle_count, saturated, input ready);
  modport sink (input valid, amplitude, particle_count, saturated, output ready);
endinterface

// ===== sv/sema_div.sv =====
module sema_div #(
  parameter int DW = 64,
  parameter int VW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int IW = $clog2(DW);

  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [IW-1:0] cnt;
  logic          busy;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;

  // one quotient bit per cycle, restoring
  assign shifted = {rem, quo[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == IW'(DW - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ~diff[VW+1]};
      rem <= diff[VW+1] ? shifted[VW-1:0] : diff[VW-1:0];
      cnt <= cnt + 1'b1;
    end
  end

  assign quotient = quo;
endmodule

// ===== sv/sema_sqrt.sv =====
module sema_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic [31:0] root,
  output logic        done
);
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitm;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  // digit-by-digit square root, two radicand bits per cycle
  assign trial = res + bitm;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == 5'd31) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitm <= sema_pkg::SQRT_TOP_BIT;
      cnt  <= '0;
    end else if (busy) begin
      if (v >= trial) begin
        v   <= v - trial;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + 1'b1;
    end
  end

  assign root = res[31:0];
endmodule

// ===== sv/sema_dp.sv =====
module sema_dp #(
  parameter int MAX_PARTICLES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  sema_pkg::dp_cmd_t  cmd,
  output sema_pkg::dp_stat_t stat,
  input  logic [31:0]        in_gamma,
  input  logic [15:0]        in_phase,
  output logic [31:0]        amplitude,
  output logic [16:0]        particle_count,
  output logic               saturated
);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  logic [31:0]   gamma_r;
  logic [15:0]   phase_r;
  logic [29:0]   x;
  logic [29:0]   x2;
  logic [31:0]   tmp;
  logic [14:0]   sinq;
  logic [14:0]   cosq;
  logic [CW-1:0] count;
  logic [63:0]   sum_gamma, sum_cos, sum_sin, sum_gc, sum_gs;
  logic [63:0]   mean, tm, gm, pa, dev;
  logic          tneg, gneg;
  logic [49:0]   re, im;
  logic [63:0]   sq_a, sq_in;
  logic          sat;

  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [14:0]   r15;
  logic [14:0]   cc, ss, cmag, smag;
  logic          cneg, sneg;
  logic [63:0]   div_dividend, div_q, rnd;
  logic          div_start, div_done;
  logic [31:0]   root;
  logic          sqrt_done;
  logic [64:0]   sq_sum;
  logic [63:0]   st_sel, sgt_sel;
  logic          same_sign;
  logic [CW+16:0] cnt_wide;

  // octant fold of the phase
  assign r15 = phase_r[13] ? (15'd16384 - {1'b0, phase_r[13:0]}) : {1'b0, phase_r[13:0]};
  assign cc  = phase_r[13] ? sinq : cosq;
  assign ss  = phase_r[13] ? cosq : sinq;

  // quadrant symmetry as magnitude and sign
  always_comb begin
    unique case (phase_r[15:14])
      2'd0: begin cmag = cc; cneg = 1'b0; smag = ss; sneg = 1'b0; end
      2'd1: begin cmag = ss; cneg = 1'b1; smag = cc; sneg = 1'b0; end
      2'd2: begin cmag = cc; cneg = 1'b1; smag = ss; sneg = 1'b1; end
      default: begin cmag = ss; cneg = 1'b0; smag = cc; sneg = 1'b1; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.op)
      sema_pkg::OP_TX:   begin mul_a = 32'(r15); mul_b = sema_pkg::RAD_PER_UNIT; end
      sema_pkg::OP_TX2:  begin mul_a = 32'(x);   mul_b = 32'(x); end
      sema_pkg::OP_SD42: begin mul_a = 32'(x2);  mul_b = sema_pkg::RCP_42; end
      sema_pkg::OP_MT2:  begin mul_a = 32'(x2);  mul_b = sema_pkg::Q30_ONE - tmp; end
      sema_pkg::OP_SD20: begin mul_a = tmp;      mul_b = sema_pkg::RCP_20; end
      sema_pkg::OP_SD6:  begin mul_a = tmp;      mul_b = sema_pkg::RCP_6; end
      sema_pkg::OP_SMX:  begin mul_a = 32'(x);   mul_b = sema_pkg::Q30_ONE - tmp; end
      sema_pkg::OP_CD56: begin mul_a = 32'(x2);  mul_b = sema_pkg::RCP_56; end
      sema_pkg::OP_CD30: begin mul_a = tmp;      mul_b = sema_pkg::RCP_30; end
      sema_pkg::OP_CD12: begin mul_a = tmp;      mul_b = sema_pkg::RCP_12; end
      sema_pkg::OP_ACC_C: begin mul_a = gamma_r; mul_b = 32'(cmag); end
      sema_pkg::OP_ACC_S: begin mul_a = gamma_r; mul_b = 32'(smag); end
      sema_pkg::OP_PLL:  begin mul_a = mean[31:0];  mul_b = tm[31:0]; end
      sema_pkg::OP_PLH:  begin mul_a = mean[31:0];  mul_b = tm[63:32]; end
      sema_pkg::OP_PHL:  begin mul_a = mean[63:32]; mul_b = tm[31:0]; end
      sema_pkg::OP_SQA:  begin mul_a = re[31:0]; mul_b = re[31:0]; end
      sema_pkg::OP_SQB:  begin mul_a = im[31:0]; mul_b = im[31:0]; end
      default:           begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  assign st_sel    = cmd.sine ? sum_sin : sum_cos;
  assign sgt_sel   = cmd.sine ? sum_gs : sum_gc;
  assign same_sign = (gneg == !tneg);
  assign rnd       = div_q + sema_pkg::ROUND_HALF;
  assign sq_sum    = {1'b0, sq_a} + {1'b0, prod};
  assign cnt_wide  = (CW + 17)'(count);

  // accumulators, cleared at reset and after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      sum_gamma <= '0;
      sum_cos   <= '0;
      sum_sin   <= '0;
      sum_gc    <= '0;
      sum_gs    <= '0;
    end else begin
      unique case (cmd.op)
        sema_pkg::OP_ACC_C: begin
          count     <= count + 1'b1;
          sum_gamma <= sum_gamma + 64'(gamma_r);
          sum_cos   <= cneg ? sum_cos - 64'(cmag) : sum_cos + 64'(cmag);
          sum_sin   <= sneg ? sum_sin - 64'(smag) : sum_sin + 64'(smag);
          sum_gc    <= cneg ? sum_gc - prod : sum_gc + prod;
        end
        sema_pkg::OP_ACC_S: sum_gs <= sneg ? sum_gs - prod : sum_gs + prod;
        sema_pkg::OP_EMIT: begin
          count     <= '0;
          sum_gamma <= '0;
          sum_cos   <= '0;
          sum_sin   <= '0;
          sum_gc    <= '0;
          sum_gs    <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sema_pkg::OP_LOAD: begin
        gamma_r <= in_gamma;
        phase_r <= in_phase;
      end
      sema_pkg::OP_TX:   x   <= prod[29:0];
      sema_pkg::OP_TX2:  x2  <= prod[59:30];
      sema_pkg::OP_SD42: tmp <= 32'(prod >> sema_pkg::SH_42);
      sema_pkg::OP_MT2,
      sema_pkg::OP_SMX:  tmp <= 32'(prod >> 30);
      sema_pkg::OP_SD20: tmp <= 32'(prod >> sema_pkg::SH_20);
      sema_pkg::OP_SD6:  tmp <= 32'(prod >> sema_pkg::SH_6);
      sema_pkg::OP_CD56: begin
        tmp  <= 32'(prod >> sema_pkg::SH_56);
        sinq <= sema_pkg::q30_to_q15(tmp);
      end
      sema_pkg::OP_CD30: tmp <= 32'(prod >> sema_pkg::SH_30);
      sema_pkg::OP_CD12: tmp <= 32'(prod >> sema_pkg::SH_12);
      sema_pkg::OP_CFIN: cosq <= sema_pkg::q30_to_q15(sema_pkg::Q30_ONE - (tmp >> 1));
      sema_pkg::OP_MEAN_CAP: mean <= div_q;
      sema_pkg::OP_MAGS: begin
        tneg <= st_sel[63];
        tm   <= st_sel[63] ? 64'd0 - st_sel : st_sel;
        gneg <= sgt_sel[63];
        gm   <= sgt_sel[63] ? 64'd0 - sgt_sel : sgt_sel;
      end
      sema_pkg::OP_PLL: pa <= prod;
      sema_pkg::OP_PLH,
      sema_pkg::OP_PHL: pa <= pa + {prod[31:0], 32'd0};
      sema_pkg::OP_DEV: begin
        if (same_sign) dev <= gm + pa;
        else if (gm >= pa) dev <= gm - pa;
        else dev <= pa - gm;
      end
      sema_pkg::OP_RND_CAP: begin
        if (cmd.sine) im <= rnd[63:14];
        else re <= rnd[63:14];
      end
      sema_pkg::OP_SQA: begin
        sq_a <= prod;
        sat  <= (|re[49:32]) || (|im[49:32]);
      end
      sema_pkg::OP_SQB: begin
        sq_in <= sq_sum[63:0];
        sat   <= sat || sq_sum[64];
      end
      sema_pkg::OP_EMIT: begin
        if (count == '0) amplitude <= '0;
        else if (sat) amplitude <= 32'hFFFF_FFFF;
        else amplitude <= root;
        particle_count <= cnt_wide[16:0];
        saturated      <= (count != '0) && sat;
      end
      default: ;
    endcase
  end

  // divider shared by mean and both components
  assign div_start    = (cmd.op == sema_pkg::OP_DIV_MEAN) || (cmd.op == sema_pkg::OP_DIV_DEV);
  assign div_dividend = (cmd.op == sema_pkg::OP_DIV_MEAN) ?
                        sum_gamma + 64'(count >> 1) : dev;

  sema_div #(.DW(64), .VW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count),
    .quotient (div_q),
    .done     (div_done)
  );

  sema_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == sema_pkg::OP_SQRT),
    .radicand (sq_in),
    .root     (root),
    .done     (sqrt_done)
  );

  assign stat.count_full = (count >= CW'(MAX_PARTICLES));
  assign stat.count_zero = (count == '0);
  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;
endmodule

// ===== sv/sema_ctrl.sv =====
module sema_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  input  logic               in_empty,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sema_pkg::dp_cmd_t  cmd,
  input  sema_pkg::dp_stat_t stat
);
  sema_pkg::state_t state, state_next;
  logic close, close_next;
  logic out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sema_pkg::ST_IDLE;
      close     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      close     <= close_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    close_next     = close;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd.op         = sema_pkg::OP_NONE;
    cmd.sine       = 1'b0;
    unique case (state)
      sema_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = sema_pkg::OP_LOAD;
          close_next = in_last || in_empty;
          if (!in_empty && !stat.count_full) state_next = sema_pkg::ST_TX;
          else if (in_last || in_empty) state_next = sema_pkg::ST_CLOSE;
        end
      end
      // sine and cosine polynomials
      sema_pkg::ST_TX:   begin cmd.op = sema_pkg::OP_TX;   state_next = sema_pkg::ST_TX2; end
      sema_pkg::ST_TX2:  begin cmd.op = sema_pkg::OP_TX2;  state_next = sema_pkg::ST_SD42; end
      sema_pkg::ST_SD42: begin cmd.op = sema_pkg::OP_SD42; state_next = sema_pkg::ST_SM1; end
      sema_pkg::ST_SM1:  begin cmd.op = sema_pkg::OP_MT2;  state_next = sema_pkg::ST_SD20; end
      sema_pkg::ST_SD20: begin cmd.op = sema_pkg::OP_SD20; state_next = sema_pkg::ST_SM2; end
      sema_pkg::ST_SM2:  begin cmd.op = sema_pkg::OP_MT2;  state_next = sema_pkg::ST_SD6; end
      sema_pkg::ST_SD6:  begin cmd.op = sema_pkg::OP_SD6;  state_next = sema_pkg::ST_SMX; end
      sema_pkg::ST_SMX:  begin cmd.op = sema_pkg::OP_SMX;  state_next = sema_pkg::ST_CD56; end
      sema_pkg::ST_CD56: begin cmd.op = sema_pkg::OP_CD56; state_next = sema_pkg::ST_CM1; end
      sema_pkg::ST_CM1:  begin cmd.op = sema_pkg::OP_MT2;  state_next = sema_pkg::ST_CD30; end
      sema_pkg::ST_CD30: begin cmd.op = sema_pkg::OP_CD30; state_next = sema_pkg::ST_CM2; end
      sema_pkg::ST_CM2:  begin cmd.op = sema_pkg::OP_MT2;  state_next = sema_pkg::ST_CD12; end
      sema_pkg::ST_CD12: begin cmd.op = sema_pkg::OP_CD12; state_next = sema_pkg::ST_CM3; end
      sema_pkg::ST_CM3:  begin cmd.op = sema_pkg::OP_MT2;  state_next = sema_pkg::ST_CFIN; end
      sema_pkg::ST_CFIN: begin cmd.op = sema_pkg::OP_CFIN; state_next = sema_pkg::ST_ACC_C; end
      sema_pkg::ST_ACC_C: begin cmd.op = sema_pkg::OP_ACC_C; state_next = sema_pkg::ST_ACC_S; end
      sema_pkg::ST_ACC_S: begin
        cmd.op     = sema_pkg::OP_ACC_S;
        state_next = close ? sema_pkg::ST_CLOSE : sema_pkg::ST_IDLE;
      end
      // slice close: mean
      sema_pkg::ST_CLOSE: begin
        if (stat.count_zero) state_next = sema_pkg::ST_EMIT;
        else begin
          cmd.op     = sema_pkg::OP_DIV_MEAN;
          state_next = sema_pkg::ST_WMEAN;
        end
      end
      sema_pkg::ST_WMEAN: begin
        if (stat.div_done) begin
          cmd.op     = sema_pkg::OP_MEAN_CAP;
          state_next = sema_pkg::ST_MAGS_C;
        end
      end
      // cosine component
      sema_pkg::ST_MAGS_C: begin cmd.op = sema_pkg::OP_MAGS; state_next = sema_pkg::ST_PLL_C; end
      sema_pkg::ST_PLL_C:  begin cmd.op = sema_pkg::OP_PLL;  state_next = sema_pkg::ST_PLH_C; end
      sema_pkg::ST_PLH_C:  begin cmd.op = sema_pkg::OP_PLH;  state_next = sema_pkg::ST_PHL_C; end
      sema_pkg::ST_PHL_C:  begin cmd.op = sema_pkg::OP_PHL;  state_next = sema_pkg::ST_DEV_C; end
      sema_pkg::ST_DEV_C:  begin cmd.op = sema_pkg::OP_DEV;  state_next = sema_pkg::ST_DIV_C; end
      sema_pkg::ST_DIV_C: begin cmd.op = sema_pkg::OP_DIV_DEV; state_next = sema_pkg::ST_WDIV_C; end
      sema_pkg::ST_WDIV_C: begin
        if (stat.div_done) begin
          cmd.op     = sema_pkg::OP_RND_CAP;
          state_next = sema_pkg::ST_MAGS_S;
        end
      end
      // sine component
      sema_pkg::ST_MAGS_S: begin
        cmd.op = sema_pkg::OP_MAGS; cmd.sine = 1'b1; state_next = sema_pkg::ST_PLL_S;
      end
      sema_pkg::ST_PLL_S: begin cmd.op = sema_pkg::OP_PLL; state_next = sema_pkg::ST_PLH_S; end
      sema_pkg::ST_PLH_S: begin cmd.op = sema_pkg::OP_PLH; state_next = sema_pkg::ST_PHL_S; end
      sema_pkg::ST_PHL_S: begin cmd.op = sema_pkg::OP_PHL; state_next = sema_pkg::ST_DEV_S; end
      sema_pkg::ST_DEV_S: begin cmd.op = sema_pkg::OP_DEV; state_next = sema_pkg::ST_DIV_S; end
      sema_pkg::ST_DIV_S: begin cmd.op = sema_pkg::OP_DIV_DEV; state_next = sema_pkg::ST_WDIV_S; end
      sema_pkg::ST_WDIV_S: begin
        if (stat.div_done) begin
          cmd.op     = sema_pkg::OP_RND_CAP;
          cmd.sine   = 1'b1;
          state_next = sema_pkg::ST_SQA;
        end
      end
      // magnitude
      sema_pkg::ST_SQA:  begin cmd.op = sema_pkg::OP_SQA;  state_next = sema_pkg::ST_SQB; end
      sema_pkg::ST_SQB:  begin cmd.op = sema_pkg::OP_SQB;  state_next = sema_pkg::ST_SQRT; end
      sema_pkg::ST_SQRT: begin cmd.op = sema_pkg::OP_SQRT; state_next = sema_pkg::ST_WSQRT; end
      sema_pkg::ST_WSQRT: begin
        if (stat.sqrt_done) state_next = sema_pkg::ST_EMIT;
      end
      // wait for a free output register
      sema_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = sema_pkg::OP_EMIT;
          out_valid_next = 1'b1;
          close_next     = 1'b0;
          state_next     = sema_pkg::ST_IDLE;
        end
      end
      default: state_next = sema_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== sv/slice_energy_modulation_amplitude.sv =====
// Slice energy-modulation amplitude, first harmonic.
// in_ch carries one particle per item (gamma Q16.16, phase as a 16-bit turn
// fraction, last, empty_slice). out_ch carries one result per closed slice:
// twice the first-harmonic modulation magnitude in Q16.16 (saturating),
// the particle count and a saturation flag.
// Each particle is accepted, then runs the octant sine/cosine polynomials
// on the shared 32x32 multiplier (ST_TX to ST_CM3), rounds the cosine
// (ST_CFIN) and accumulates (ST_ACC_C, ST_ACC_S). Particles beyond
// MAX_PARTICLES are accepted and dropped.
// Closing a slice runs three 64-step divisions (mean and the two
// components) and a 32-step square root on one shared divider and one
// root unit. An empty slice skips them and goes straight to its result.
// in_ch.ready is high only while the controller is idle.
// Results sit in an output register: a stalled receiver does not block
// the next particles; only the next slice close waits for the register.
// Reset (synchronous) clears all accumulators and drops any pending result.
module slice_energy_modulation_amplitude #(
  parameter int MAX_PARTICLES = 65536
) (
  input logic        clk,
  input logic        rst,
  sema_in_if.sink    in_ch,
  sema_out_if.source out_ch
);
  sema_pkg::dp_cmd_t  cmd;
  sema_pkg::dp_stat_t stat;

  sema_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_empty  (in_ch.empty_slice),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sema_dp #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .in_gamma       (in_ch.gamma),
    .in_phase       (in_ch.phase),
    .amplitude      (out_ch.amplitude),
    .particle_count (out_ch.particle_count),
    .saturated      (out_ch.saturated)
  );
endmodule

// ===== sv/sema_chk.sv =====
module sema_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] amplitude,
  input logic [16:0] particle_count,
  input logic        saturated
);
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(amplitude) &&
    $stable(particle_count) && $stable(saturated))
    else $error("result changed while stalled");

  // clipped results read full scale
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> amplitude == 32'hFFFF_FFFF)
    else $error("saturated result not full scale");

  // reset drops any pending result
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a result is never raised right after an item is taken
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result raised in the cycle after accept");
endmodule

bind slice_energy_modulation_amplitude sema_chk u_sema_chk (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .amplitude      (out_ch.amplitude),
  .particle_count (out_ch.particle_count),
  .saturated      (out_ch.saturated)
);

// ===== tb/slice_energy_modulation_amplitude_tb.sv =====
module slice_energy_modulation_amplitude_tb;

  typedef struct packed {
    logic [31:0] gamma;
    logic [15:0] phase;
    logic        last;
    logic        empty_slice;
  } particle_t;

  typedef struct packed {
    logic [31:0] amplitude;
    logic [16:0] particle_count;
    logic        saturated;
  } slice_result_t;

  localparam int MAX_PARTICLES = 65536;
  localparam logic [31:0] AMP_SAT = 32'hFFFF_FFFF;

  logic clk;
  logic rst;

  sema_in_if in_ch();
  sema_out_if out_ch();

  slice_energy_modulation_amplitude #(.MAX_PARTICLES(MAX_PARTICLES)) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // slice accumulators of the predictor
  logic [63:0] acc_count, acc_gamma, acc_cos, acc_sin, acc_gcos, acc_gsin;

  particle_t     pending_particles[$];
  slice_result_t expected_slices[$];
  int mismatches;
  int results_seen;
  int sat_seen;
  bit stim_done;
  bit calm_tail;
  bit hold_sink;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // octant polynomials in Q30, result rounded to Q1.15
  function automatic logic [63:0] to_q15(logic [63:0] v);
    logic [63:0] r;
    r = (v + 64'd16384) >> 15;
    return (r > 64'd32767) ? 64'd32767 : r;
  endfunction

  function automatic logic [63:0] oct_sine(logic [63:0] r);
    logic [63:0] x, x2, t;
    x  = r * 64'd102944;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 64'd42;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    return to_q15((x * t) >> 30);
  endfunction

  function automatic logic [63:0] oct_cosine(logic [63:0] r);
    logic [63:0] x, x2, t;
    x  = r * 64'd102944;
    x2 = (x * x) >> 30;
    t  = (64'd1 << 30) - x2 / 64'd56;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd30;
    t  = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd12;
    return to_q15((64'd1 << 30) - ((x2 * t) >> 30) / 64'd2);
  endfunction

  // |sum_gt - mean*sum_t| in sign-magnitude form
  function automatic logic [63:0] deviation_mag(logic [63:0] sgt, logic [63:0] st,
                                                logic [63:0] mean);
    logic gneg, tneg;
    logic [63:0] gm, tm, p;
    gneg = sgt[63];
    tneg = st[63];
    gm = gneg ? -sgt : sgt;
    tm = tneg ? -st : st;
    p = mean * tm;
    if (gneg == !tneg) return gm + p;
    return (gm >= p) ? gm - p : p - gm;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // accumulate one particle; queue a result when the slice closes
  task automatic predict_particle(particle_t p);
    logic [63:0] cc, ss, c, s, n, mean, re, im, a, b, amp;
    logic [1:0]  quad;
    logic [13:0] off;
    logic sat;
    slice_result_t r;
    if (!p.empty_slice && acc_count < MAX_PARTICLES) begin
      quad = p.phase[15:14];
      off  = p.phase[13:0];
      if (off < 14'd8192) begin
        cc = oct_cosine(off);
        ss = oct_sine(off);
      end else begin
        cc = oct_sine(64'd16384 - off);
        ss = oct_cosine(64'd16384 - off);
      end
      case (quad)
        2'd0: begin c = cc;  s = ss;  end
        2'd1: begin c = -ss; s = cc;  end
        2'd2: begin c = -cc; s = -ss; end
        default: begin c = ss; s = -cc; end
      endcase
      acc_count = acc_count + 1;
      acc_gamma = acc_gamma + p.gamma;
      acc_cos   = acc_cos + c;
      acc_sin   = acc_sin + s;
      acc_gcos  = acc_gcos + {32'd0, p.gamma} * c;
      acc_gsin  = acc_gsin + {32'd0, p.gamma} * s;
    end
    if (!p.empty_slice && !p.last) return;
    amp = 0;
    sat = 1'b0;
    if (acc_count != 0) begin
      n = acc_count;
      mean = (acc_gamma + n / 2) / n;
      re = ((deviation_mag(acc_gcos, acc_cos, mean) / n) + 64'd8192) >> 14;
      im = ((deviation_mag(acc_gsin, acc_sin, mean) / n) + 64'd8192) >> 14;
      if (re >= (64'd1 << 32) || im >= (64'd1 << 32)) begin
        sat = 1'b1;
      end else begin
        a = re * re;
        b = im * im;
        if (a > ~b) sat = 1'b1;
        else amp = int_sqrt(a + b);
      end
      if (sat) amp = AMP_SAT;
    end
    r.amplitude = amp[31:0];
    r.particle_count = acc_count[16:0];
    r.saturated = sat;
    expected_slices.push_back(r);
    {acc_count, acc_gamma, acc_cos, acc_sin, acc_gcos, acc_gsin} = '0;
  endtask

  function automatic particle_t rand_particle(bit close_it);
    particle_t p;
    case ($urandom_range(0, 5))
      0: p.gamma = $urandom;
      1: p.gamma = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : 32'd0;
      default: p.gamma = 32'h0001_0000 + $urandom_range(0, 32'h0000_3FFF)
                         + ($urandom_range(0, 1) ? 32'h00FF_0000 : 32'd0);
    endcase
    p.phase = $urandom;
    p.last = close_it;
    p.empty_slice = 1'b0;
    return p;
  endfunction

  task automatic add_slice(int n);
    for (int i = 0; i < n; i++) pending_particles.push_back(rand_particle(i == n - 1));
  endtask

  // driver: offers queued items, idles in random bursts
  int src_gap;
  bit src_hold;
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_particle(pending_particles.pop_front());
      end
      // an offered item stays put until it is taken
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (src_gap > 0) src_gap--;
        else if (!calm_tail && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 7);
        if (pending_particles.size() != 0 && src_gap == 0 && !src_hold) begin
          in_ch.valid <= 1'b1;
          {in_ch.gamma, in_ch.phase, in_ch.last, in_ch.empty_slice} <= pending_particles[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver stall countdown
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles--;
  end

  // monitor: checks each result against the oldest expectation
  int snk_gap;
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_slices.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result amp=%h n=%0d",
                                         out_ch.amplitude, out_ch.particle_count);
        end else begin
          slice_result_t e;
          e = expected_slices.pop_front();
          if (out_ch.saturated) sat_seen++;
          if (out_ch.amplitude !== e.amplitude || out_ch.particle_count !== e.particle_count
              || out_ch.saturated !== e.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp amp=%h n=%0d sat=%b got amp=%h n=%0d sat=%b",
                       e.amplitude, e.particle_count, e.saturated, out_ch.amplitude,
                       out_ch.particle_count, out_ch.saturated);
          end
        end
      end
      if (snk_gap > 0) snk_gap--;
      else if (!calm_tail && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 7);
      out_ch.ready <= (snk_gap == 0) && !hold_sink && hold_cycles == 0;
    end
  end

  initial begin
    particle_t p;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.gamma = '0;
    in_ch.phase = '0;
    in_ch.last = 1'b0;
    in_ch.empty_slice = 1'b0;
    out_ch.ready = 1'b0;
    {acc_count, acc_gamma, acc_cos, acc_sin, acc_gcos, acc_gsin} = '0;
    mismatches = 0;
    results_seen = 0;
    sat_seen = 0;
    stim_done = 0;
    calm_tail = 0;
    hold_sink = 0;
    hold_cycles = 0;
    src_hold = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty slice, single particles at extremes, every phase octant
    p = '0; p.empty_slice = 1'b1; pending_particles.push_back(p);
    p = '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0}; pending_particles.push_back(p);
    p = '{32'd0, 16'd0, 1'b1, 1'b0}; pending_particles.push_back(p);
    for (int k = 0; k < 8; k++) begin
      p = '{(k % 2) ? 32'hFFFF_FFFF : 32'h0001_0000, 16'(k * 8192 + 4096), k == 7, 1'b0};
      pending_particles.push_back(p);
    end
    // extreme spread at large gamma with opposite phases, amplitude just below full scale
    p = '{32'hFFFF_FFFF, 16'h0000, 1'b0, 1'b0}; pending_particles.push_back(p);
    p = '{32'h0000_0000, 16'h8000, 1'b1, 1'b0}; pending_particles.push_back(p);
    // empty item closing a partly filled slice; phase boundary values
    p = '{32'h0002_0000, 16'h2000, 1'b0, 1'b0}; pending_particles.push_back(p);
    p = '{32'h0003_0000, 16'h3FFF, 1'b0, 1'b0}; pending_particles.push_back(p);
    p = '{32'hFFFF_FFFF, 16'h4000, 1'b0, 1'b1}; pending_particles.push_back(p);
    wait (pending_particles.size() == 0 && expected_slices.size() == 0);

    // long receiver stall while further slices are offered
    hold_cycles = 3000;
    for (int i = 0; i < 20; i++) add_slice($urandom_range(1, 4));
    wait (pending_particles.size() == 0 && expected_slices.size() == 0);

    // sender pause until all results are in
    for (int i = 0; i < 20; i++) add_slice($urandom_range(1, 3));
    wait (pending_particles.size() == 0 && expected_slices.size() == 0);
    repeat (20) @(posedge clk);

    // random slices, mostly short, a few empty
    while (results_seen < 400 && pending_particles.size() + 0 < 100000) begin
      if ($urandom_range(0, 15) == 0) begin
        p = rand_particle(1'b0);
        p.empty_slice = 1'b1;
        p.last = $urandom;
        pending_particles.push_back(p);
      end else begin
        add_slice($urandom_range(1, 8));
      end
      if (pending_particles.size() > 1250) break;
    end
    wait (pending_particles.size() < 100);
    calm_tail = 1;
    for (int i = 0; i < 10; i++) add_slice($urandom_range(1, 6));
    wait (pending_particles.size() == 0 && expected_slices.size() == 0);
    repeat (400) @(posedge clk);
    $display("covered %0d slices (%0d saturated) incl. empty slices, octants, stalls",
             results_seen, sat_seen);
    if (mismatches == 0 && expected_slices.size() == 0) begin
      $display("PASS slice_energy_modulation_amplitude");
    end else begin
      $display("FAIL slice_energy_modulation_amplitude");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL slice_energy_modulation_amplitude");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sema_pkg.sv
sv/sema_in_if.sv
sv/sema_out_if.sv
sv/sema_div.sv
sv/sema_sqrt.sv
sv/sema_dp.sv
sv/sema_ctrl.sv
sv/slice_energy_modulation_amplitude.sv
sv/sema_chk.sv
tb/slice_energy_modulation_amplitude_tb.sv
